FILE: rtl/sic_pkg.sv
// shared widths, codes and helper functions for the segment intersection classifier
// no dependencies; imported by sic_divider and the core
package sic_pkg;

	localparam int COORD_W    = 24;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int WIDE_W     = PROD_W + 1;
	localparam int T_W        = 32;
	localparam int DTOL_W     = 32;
	localparam int PTOL_W     = 12;
	localparam int TOL_W      = PTOL_W + 4;
	localparam int INT_W      = 15;
	localparam int FRAC_W     = 16;
	localparam int Q_W        = INT_W + FRAC_W;
	localparam int DIV_LAT    = Q_W + 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int X_W        = T_W + 2;

	localparam logic [DTOL_W-1:0] DET_TOL_RST   = 32'd1;
	localparam logic [PTOL_W-1:0] PARAM_TOL_RST = 12'd4;

	localparam logic [T_W-1:0] T_MAX = 32'h7fff_ffff;
	localparam logic [T_W-1:0] T_MIN = 32'h8000_0000;

	localparam logic signed [X_W-1:0] ONE_X  = 34'sd65536;
	localparam logic signed [X_W-1:0] ZERO_X = 34'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DET_TOL   = 1'b0,
		REG_PARAM_TOL = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REL_NONE   = 2'd0,
		REL_CROSS  = 2'd1,
		REL_Q_IN_P = 2'd2,
		REL_P_IN_Q = 2'd3
	} rel_t;

	// flags that travel beside the dividers
	typedef struct packed {
		logic valid;
		logic nonpar;
		logic colin;
		logic range_ok;
	} side_t;

	function automatic logic signed [X_W-1:0] sext_t(input logic signed [T_W-1:0] x);
		return {{(X_W-T_W){x[T_W-1]}}, x};
	endfunction

	function automatic logic signed [X_W-1:0] ext_tol(input logic [TOL_W-1:0] tol);
		return $signed({{(X_W-TOL_W){1'b0}}, tol});
	endfunction

	function automatic logic in_half(input logic signed [T_W-1:0] x,
			input logic [TOL_W-1:0] tol);
		logic signed [X_W-1:0] s;
		s = sext_t(x) + ext_tol(tol);
		return (s > ZERO_X) && (s < ONE_X);
	endfunction

	function automatic logic near_range(input logic signed [T_W-1:0] x,
			input logic [TOL_W-1:0] tol);
		logic signed [X_W-1:0] s;
		logic signed [X_W-1:0] d;
		s = sext_t(x) + ext_tol(tol);
		d = sext_t(x) - ext_tol(tol);
		return (s > ZERO_X) && (d < ONE_X);
	endfunction

	// |x - off| < tol
	function automatic logic near_val(input logic signed [T_W-1:0] x,
			input logic signed [X_W-1:0] off, input logic [TOL_W-1:0] tol);
		logic signed [X_W-1:0] e;
		e = sext_t(x) - off;
		return (e > -ext_tol(tol)) && (e < ext_tol(tol));
	endfunction

endpackage

FILE: rtl/segment_intersection_classifier_core.sv
// top level of the segment intersection classifier: front pipeline, four dividers, output skid
// depends on sic_pkg and sic_divider
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    p_start_x .. q_end_y
//  out      output     out_valid / out_stall  relation, t_first, t_second
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one segment pair per cycle while in_stall is low; the path is 4 front stages, 34 divider stages
// (the one-bit-per-stage quotient pipeline) and the output register
// reset clears the valid bits, including those of the output and skid registers, and restores the tolerances
// a stall at the output fills a one-word skid register; the pipeline freezes only while it is full
// cfg_ready is always high
module segment_intersection_classifier_core import sic_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_W-1:0]    p_start_x,
	input  logic signed [COORD_W-1:0]    p_start_y,
	input  logic signed [COORD_W-1:0]    p_end_x,
	input  logic signed [COORD_W-1:0]    p_end_y,
	input  logic signed [COORD_W-1:0]    q_start_x,
	input  logic signed [COORD_W-1:0]    q_start_y,
	input  logic signed [COORD_W-1:0]    q_end_x,
	input  logic signed [COORD_W-1:0]    q_end_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   relation,
	output logic signed [T_W-1:0]        t_first,
	output logic signed [T_W-1:0]        t_second,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	logic [DTOL_W-1:0] det_tol_q;
	logic [PTOL_W-1:0] param_tol_q;
	logic [TOL_W-1:0]  tol;

	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign cfg_ready = 1'b1;
	assign en        = !skid_v_q;
	assign in_stall  = skid_v_q;
	assign tol       = {param_tol_q, 4'b0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_tol_q   <= DET_TOL_RST;
			param_tol_q <= PARAM_TOL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DET_TOL:   det_tol_q   <= cfg_data[DTOL_W-1:0];
				REG_PARAM_TOL: param_tol_q <= cfg_data[PTOL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: coordinate differences
	logic v_s1;
	logic signed [DIFF_W-1:0] a1_s1, a2_s1, b1_s1, b2_s1, c1_s1, c2_s1;
	logic signed [DIFF_W-1:0] qex_s1, qey_s1, pqx_s1, pqy_s1, pex_s1, pey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1  <= {p_end_x[COORD_W-1], p_end_x} - {p_start_x[COORD_W-1], p_start_x};
			a2_s1  <= {p_end_y[COORD_W-1], p_end_y} - {p_start_y[COORD_W-1], p_start_y};
			b1_s1  <= {q_end_x[COORD_W-1], q_end_x} - {q_start_x[COORD_W-1], q_start_x};
			b2_s1  <= {q_end_y[COORD_W-1], q_end_y} - {q_start_y[COORD_W-1], q_start_y};
			c1_s1  <= {q_start_x[COORD_W-1], q_start_x} - {p_start_x[COORD_W-1], p_start_x};
			c2_s1  <= {q_start_y[COORD_W-1], q_start_y} - {p_start_y[COORD_W-1], p_start_y};
			qex_s1 <= {q_end_x[COORD_W-1], q_end_x} - {p_start_x[COORD_W-1], p_start_x};
			qey_s1 <= {q_end_y[COORD_W-1], q_end_y} - {p_start_y[COORD_W-1], p_start_y};
			pqx_s1 <= {p_start_x[COORD_W-1], p_start_x} - {q_start_x[COORD_W-1], q_start_x};
			pqy_s1 <= {p_start_y[COORD_W-1], p_start_y} - {q_start_y[COORD_W-1], q_start_y};
			pex_s1 <= {p_end_x[COORD_W-1], p_end_x} - {q_start_x[COORD_W-1], q_start_x};
			pey_s1 <= {p_end_y[COORD_W-1], p_end_y} - {q_start_y[COORD_W-1], q_start_y};
		end
	end

	// stage 2: products, projection axis choice
	logic v_s2;
	logic signed [PROD_W-1:0] b1a2_s2, b2a1_s2, a1c2_s2, a2c1_s2, c2b1_s2, c1b2_s2;
	logic signed [DIFF_W-1:0] cn_s2 [0:3];
	logic signed [DIFF_W-1:0] cdq_s2, cdp_s2;
	logic sel_y;

	assign sel_y = (a1_s1 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b1a2_s2 <= PROD_W'(b1_s1) * PROD_W'(a2_s1);
			b2a1_s2 <= PROD_W'(b2_s1) * PROD_W'(a1_s1);
			a1c2_s2 <= PROD_W'(a1_s1) * PROD_W'(c2_s1);
			a2c1_s2 <= PROD_W'(a2_s1) * PROD_W'(c1_s1);
			c2b1_s2 <= PROD_W'(c2_s1) * PROD_W'(b1_s1);
			c1b2_s2 <= PROD_W'(c1_s1) * PROD_W'(b2_s1);
			cn_s2[0] <= sel_y ? c2_s1  : c1_s1;
			cn_s2[1] <= sel_y ? qey_s1 : qex_s1;
			cn_s2[2] <= sel_y ? pqy_s1 : pqx_s1;
			cn_s2[3] <= sel_y ? pey_s1 : pex_s1;
			cdq_s2   <= sel_y ? a2_s1  : a1_s1;
			cdp_s2   <= sel_y ? b2_s1  : b1_s1;
		end
	end

	// stage 3: determinant and cross terms
	logic v_s3;
	logic signed [WIDE_W-1:0] det_s3, cross_s3, n0_s3;
	logic signed [DIFF_W-1:0] cn_s3 [0:3];
	logic signed [DIFF_W-1:0] cdq_s3, cdp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3   <= {b1a2_s2[PROD_W-1], b1a2_s2} - {b2a1_s2[PROD_W-1], b2a1_s2};
			cross_s3 <= {a1c2_s2[PROD_W-1], a1c2_s2} - {a2c1_s2[PROD_W-1], a2c1_s2};
			n0_s3    <= {c2b1_s2[PROD_W-1], c2b1_s2} - {c1b2_s2[PROD_W-1], c1b2_s2};
			cn_s3    <= cn_s2;
			cdq_s3   <= cdq_s2;
			cdp_s3   <= cdp_s2;
		end
	end

	// stage 4: parallel tests, range tests, divider operands
	side_t side_s4;
	logic signed [WIDE_W-1:0] num_s4 [0:3];
	logic signed [WIDE_W-1:0] den_s4 [0:3];
	logic [WIDE_W-1:0] abs_det, abs_cross, dtol_w;
	logic nonpar, colin, ok0, ok1;

	always_comb begin
		abs_det   = det_s3[WIDE_W-1]   ? WIDE_W'(-det_s3)   : WIDE_W'(det_s3);
		abs_cross = cross_s3[WIDE_W-1] ? WIDE_W'(-cross_s3) : WIDE_W'(cross_s3);
		dtol_w    = {{(WIDE_W-DTOL_W){1'b0}}, det_tol_q};
		nonpar    = abs_det > dtol_w;
		colin     = !nonpar && (abs_cross <= dtol_w);
		if (!det_s3[WIDE_W-1]) begin
			ok0 = (n0_s3 > 0) && (n0_s3 <= det_s3);
			ok1 = (cross_s3 > 0) && (cross_s3 < det_s3);
		end else begin
			ok0 = (n0_s3 < 0) && (n0_s3 >= det_s3);
			ok1 = (cross_s3 < 0) && (cross_s3 > det_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (en) begin
			side_s4.valid    <= v_s3;
			side_s4.nonpar   <= nonpar;
			side_s4.colin    <= colin;
			side_s4.range_ok <= ok0 && ok1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4[0] <= nonpar ? n0_s3    : WIDE_W'(cn_s3[0]);
			num_s4[1] <= nonpar ? cross_s3 : WIDE_W'(cn_s3[1]);
			num_s4[2] <= WIDE_W'(cn_s3[2]);
			num_s4[3] <= WIDE_W'(cn_s3[3]);
			den_s4[0] <= nonpar ? det_s3   : WIDE_W'(cdq_s3);
			den_s4[1] <= nonpar ? det_s3   : WIDE_W'(cdq_s3);
			den_s4[2] <= WIDE_W'(cdp_s3);
			den_s4[3] <= WIDE_W'(cdp_s3);
		end
	end

	// dividers
	logic signed [T_W-1:0] quo [0:3];

	for (genvar u = 0; u < 4; u++) begin : g_div
		sic_divider u_div (
			.clk (clk),
			.en  (en),
			.num (num_s4[u]),
			.den (den_s4[u]),
			.res (quo[u])
		);
	end

	// flags line matching the divider latency
	side_t side_s [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				side_s[i] <= '0;
			end
		end else if (en) begin
			side_s[0] <= side_s4;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// final classification
	side_t fin;
	rel_t  fin_rel;
	logic signed [T_W-1:0] fin_t0, fin_t1;
	logic iq1, iq2, ip1, ip2;
	logic fin_v;

	assign fin   = side_s[DIV_LAT-1];
	assign fin_v = fin.valid && en;

	always_comb begin
		iq1 = in_half(quo[0], tol);
		iq2 = in_half(quo[1], tol);
		ip1 = in_half(quo[2], tol);
		ip2 = in_half(quo[3], tol);
		fin_rel = REL_NONE;
		fin_t0  = '0;
		fin_t1  = '0;
		if (fin.nonpar) begin
			if (fin.range_ok) begin
				fin_rel = REL_CROSS;
				fin_t0  = quo[0];
				fin_t1  = quo[1];
			end
		end else if (fin.colin) begin
			priority if (iq1 && iq2) begin
				fin_rel = REL_Q_IN_P;
				fin_t0  = quo[0];
				fin_t1  = quo[1];
			end else if (!iq1 && iq2) begin
				fin_rel = REL_CROSS;
				fin_t0  = quo[1];
				fin_t1  = quo[2];
			end else if (iq1 && !iq2) begin
				fin_rel = REL_CROSS;
				fin_t0  = quo[0];
				fin_t1  = quo[3];
			end else if (ip1 && ip2) begin
				fin_rel = REL_P_IN_Q;
				fin_t0  = quo[2];
				fin_t1  = quo[3];
			end else if (near_val(quo[0], ZERO_X, tol) && near_val(quo[1], ONE_X, tol)) begin
				fin_rel = REL_NONE;
			end else if (!near_range(quo[0], tol) || !near_range(quo[1], tol) ||
					!near_range(quo[2], tol) || !near_range(quo[3], tol)) begin
				fin_rel = REL_NONE;
			end else begin
				// overlap with no parameters to report
				fin_rel = REL_CROSS;
			end
		end
		if (fin_rel == REL_NONE) begin
			fin_t0 = '0;
			fin_t1 = '0;
		end
	end

	// output register and skid word
	rel_t rel_q, skid_rel_q;
	logic signed [T_W-1:0] t0_q, t1_q, skid_t0_q, skid_t1_q;
	logic load_out, load_skid;

	assign load_out  = skid_v_q ? !out_stall : (!out_v_q || !out_stall);
	assign load_skid = !skid_v_q && out_v_q && out_stall && fin_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (!out_stall) begin
					skid_v_q <= 1'b0;
				end
			end else if (!out_v_q || !out_stall) begin
				out_v_q <= fin_v;
			end else if (fin_v) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rel_q <= skid_v_q ? skid_rel_q : fin_rel;
			t0_q  <= skid_v_q ? skid_t0_q  : fin_t0;
			t1_q  <= skid_v_q ? skid_t1_q  : fin_t1;
		end
		if (load_skid) begin
			skid_rel_q <= fin_rel;
			skid_t0_q  <= fin_t0;
			skid_t1_q  <= fin_t1;
		end
	end

	assign out_valid = out_v_q;
	assign relation  = rel_q;
	assign t_first   = t0_q;
	assign t_second  = t1_q;

endmodule

FILE: rtl/sic_divider.sv
// pipelined restoring divider giving a saturated signed q16.16 quotient, one bit per stage
// depends on sic_pkg
module sic_divider import sic_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [WIDE_W-1:0] num,
	input  logic signed [WIDE_W-1:0] den,
	output logic signed [T_W-1:0]    res
);

	localparam int R_W = WIDE_W + 1;

	logic              neg_s1;
	logic [WIDE_W-1:0] n_s1;
	logic [WIDE_W-1:0] d_s1;

	logic              neg_s2;
	logic              sat_s2;
	logic [WIDE_W-1:0] d_s2;
	logic [INT_W-1:0]  low_s2;
	logic [R_W-1:0]    rem_s2;

	// step pipeline, entry 0 is the prepared stage
	logic              neg_s  [0:Q_W];
	logic              sat_s  [0:Q_W];
	logic [WIDE_W-1:0] d_s    [0:Q_W];
	logic [INT_W-1:0]  low_s  [0:Q_W];
	logic [R_W-1:0]    rem_s  [0:Q_W];
	logic [Q_W-1:0]    quot_s [0:Q_W];

	logic signed [T_W-1:0] res_sl;
	logic        [T_W-1:0] q_ext;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[WIDE_W-1] ^ den[WIDE_W-1];
			n_s1   <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
			d_s1   <= den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			sat_s2 <= (n_s1 >> INT_W) >= d_s1;
			d_s2   <= d_s1;
			low_s2 <= n_s1[INT_W-1:0];
			rem_s2 <= {1'b0, n_s1 >> INT_W};
		end
	end

	assign neg_s[0]  = neg_s2;
	assign sat_s[0]  = sat_s2;
	assign d_s[0]    = d_s2;
	assign low_s[0]  = low_s2;
	assign rem_s[0]  = rem_s2;
	assign quot_s[0] = '0;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [R_W-1:0] trial;
		logic           ge;
		always_comb begin
			trial = {rem_s[k][R_W-2:0], low_s[k][INT_W-1]};
			ge    = trial >= {1'b0, d_s[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1]  <= neg_s[k];
				sat_s[k+1]  <= sat_s[k];
				d_s[k+1]    <= d_s[k];
				low_s[k+1]  <= {low_s[k][INT_W-2:0], 1'b0};
				rem_s[k+1]  <= ge ? R_W'(trial - {1'b0, d_s[k]}) : trial;
				quot_s[k+1] <= {quot_s[k][Q_W-2:0], ge};
			end
		end
	end

	assign q_ext = {1'b0, quot_s[Q_W]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[Q_W]) begin
				res_sl <= neg_s[Q_W] ? $signed(T_MIN) : $signed(T_MAX);
			end else begin
				res_sl <= neg_s[Q_W] ? $signed(T_W'(-q_ext)) : $signed(q_ext);
			end
		end
	end

	assign res = res_sl;

endmodule

FILE: test/testbench.sv
// self-checking testbench for segment_intersection_classifier_core
// depends on sic_pkg and the core; predicts each classification and checks it in order
module testbench;
	import sic_pkg::*;

	localparam int LATENCY = 39;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [1:0] rel;
		logic [31:0] t0;
		logic [31:0] t1;
	} verdict_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t p_start_x = '0, p_start_y = '0, p_end_x = '0, p_end_y = '0;
	coord_t q_start_x = '0, q_start_y = '0, q_end_x = '0, q_end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] relation;
	logic signed [T_W-1:0] t_first, t_second;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	verdict_t pending_verdicts[$];
	int mismatches = 0;
	int cycles = 0;
	longint det_tol_m = 1;
	longint param_tol_m = 4;
	bit stall_free = 0;

	segment_intersection_classifier_core DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// saturated Q16.16 quotient with magnitude truncated toward zero
	function automatic longint quot_q16(longint num, longint den);
		longint n, d, ip, rem, frac;
		bit neg;
		if (den == 0)
			return num < 0 ? -64'sd2147483648 : 64'sd2147483647;
		neg = (num < 0) != (den < 0);
		n = mag(num);
		d = mag(den);
		ip = n / d;
		if (ip >= 32768)
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		rem = n % d;
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= d) begin
				rem = rem - d;
				frac = frac | 1;
			end
		end
		return neg ? -((ip << 16) | frac) : ((ip << 16) | frac);
	endfunction

	function automatic bit ratio_in_unit(longint num, longint den, bit closed_top);
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (num <= 0)
			return 0;
		return closed_top ? (num <= den) : (num < den);
	endfunction

	function automatic bit half_open(longint x, longint tol);
		return (x + tol > 0) && (x + tol < 65536);
	endfunction

	function automatic bit near_unit(longint x, longint tol);
		return (x + tol > 0) && (x - tol < 65536);
	endfunction

	function automatic verdict_t classify(coord_t c[8]);
		verdict_t v;
		longint psx, psy, pex, pey, qsx, qsy, qex, qey;
		longint a1, a2, b1, b2, c1, c2, det, crs, tol, n0, t0, t1;
		longint qt1, qt2, pt1, pt2;
		bit iq1, iq2, ip1, ip2;
		rel_t rel;
		psx = c[0]; psy = c[1]; pex = c[2]; pey = c[3];
		qsx = c[4]; qsy = c[5]; qex = c[6]; qey = c[7];
		a1 = pex - psx; a2 = pey - psy;
		b1 = qex - qsx; b2 = qey - qsy;
		c1 = qsx - psx; c2 = qsy - psy;
		det = b1 * a2 - b2 * a1;
		crs = a1 * c2 - a2 * c1;
		tol = param_tol_m << 4;
		rel = REL_NONE;
		t0 = 0;
		t1 = 0;
		if (mag(det) > det_tol_m) begin
			n0 = c2 * b1 - c1 * b2;
			if (ratio_in_unit(n0, det, 1) && ratio_in_unit(crs, det, 0)) begin
				rel = REL_CROSS;
				t0 = quot_q16(n0, det);
				t1 = quot_q16(crs, det);
			end
		end else if (mag(crs) <= det_tol_m) begin
			// vertical P projects on y
			if (a1 == 0) begin
				qt1 = quot_q16(qsy - psy, a2);
				qt2 = quot_q16(qey - psy, a2);
				pt1 = quot_q16(psy - qsy, b2);
				pt2 = quot_q16(pey - qsy, b2);
			end else begin
				qt1 = quot_q16(qsx - psx, a1);
				qt2 = quot_q16(qex - psx, a1);
				pt1 = quot_q16(psx - qsx, b1);
				pt2 = quot_q16(pex - qsx, b1);
			end
			iq1 = half_open(qt1, tol);
			iq2 = half_open(qt2, tol);
			ip1 = half_open(pt1, tol);
			ip2 = half_open(pt2, tol);
			if (iq1 && iq2) begin
				rel = REL_Q_IN_P; t0 = qt1; t1 = qt2;
			end else if (!iq1 && iq2) begin
				rel = REL_CROSS; t0 = qt2; t1 = pt1;
			end else if (iq1 && !iq2) begin
				rel = REL_CROSS; t0 = qt1; t1 = pt2;
			end else if (ip1 && ip2) begin
				rel = REL_P_IN_Q; t0 = pt1; t1 = pt2;
			end else if (mag(qt1) < tol && mag(qt2 - 65536) < tol) begin
				rel = REL_NONE;
			end else if (!near_unit(qt1, tol) || !near_unit(qt2, tol) ||
					!near_unit(pt1, tol) || !near_unit(pt2, tol)) begin
				rel = REL_NONE;
			end else begin
				rel = REL_CROSS;
			end
		end
		if (rel == REL_NONE) begin
			t0 = 0;
			t1 = 0;
		end
		v.rel = rel;
		v.t0 = t0[31:0];
		v.t1 = t1[31:0];
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		mismatches++;
	endtask

	// result checker and receiver-side stall
	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected word", relation, 0);
			end else begin
				w = pending_verdicts.pop_front();
				if (relation !== w.rel) report_mismatch("relation", relation, w.rel);
				if (t_first !== w.t0) report_mismatch("t_first", t_first, w.t0);
				if (t_second !== w.t1) report_mismatch("t_second", t_second, w.t1);
			end
		end
	end

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (stall_free) begin
				out_stall <= 1'b0;
			end else begin
				n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n - 1) @(negedge clk);
				end
				@(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// valid stays high after a word so back-to-back words need no extra edge
	task automatic send_pair(coord_t c[8]);
		int gap;
		gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{p_start_x, p_start_y, p_end_x, p_end_y} <= {c[0], c[1], c[2], c[3]};
		{q_start_x, q_start_y, q_end_x, q_end_y} <= {c[4], c[5], c[6], c[7]};
		in_valid <= 1'b1;
		pending_verdicts.push_back(classify(c));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DET_TOL) det_tol_m = data;
		else param_tol_m = data[11:0];
	endtask

	function automatic coord_t rnd_coord(int span);
		case ($urandom_range(0, 5))
			0: return 24'sh7fffff;
			1: return -24'sh800000;
			2: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	task automatic test_directed;
		coord_t c[8];
		c = '{0, 0, 24'sh1000, 24'sh1000, 0, 24'sh1000, 24'sh1000, 0};
		send_pair(c); // plain crossing
		c = '{0, 0, 24'sh1000, 0, 24'sh400, 0, 24'sh800, 0};
		send_pair(c); // q within p
		c = '{24'sh400, 0, 24'sh800, 0, 0, 0, 24'sh1000, 0};
		send_pair(c); // p within q
		c = '{0, 0, 24'sh1000, 0, 24'sh800, 0, 24'sh1800, 0};
		send_pair(c); // partial overlap
		c = '{0, 0, 0, 24'sh1000, 0, 24'sh400, 0, 24'sh1800};
		send_pair(c); // vertical p
		c = '{0, 0, 24'sh1000, 0, 0, 24'sh100, 24'sh1000, 24'sh100};
		send_pair(c); // parallel apart
		c = '{0, 0, 24'sh1000, 0, 0, 0, 24'sh1000, 0};
		send_pair(c); // identical
		c = '{0, 0, 24'sh1000, 0, 24'sh800, 0, 24'sh800, 0};
		send_pair(c); // degenerate q, division by zero
		c = '{0, 0, 0, 0, 0, 0, 0, 0};
		send_pair(c); // all degenerate
		c = '{-24'sh800000, -24'sh800000, 24'sh7fffff, 24'sh7fffff,
			-24'sh800000, 24'sh7fffff, 24'sh7fffff, -24'sh800000};
		send_pair(c); // extreme corners
		c = '{0, 0, 24'sh1000, 24'sh1000, 24'sh1000, 24'sh1000, 24'sh2000, 0};
		send_pair(c); // touch at p end
		c = '{0, 0, 24'sh1000, 24'sh1000, 0, 0, 24'sh1000, -24'sh1000};
		send_pair(c); // touch at p start
		c = '{0, 0, 24'sh1, 0, 0, 0, 24'sh7fffff, 0};
		send_pair(c); // saturation of projected parameter
		c = '{24'sh7fffff, -24'sh800000, -24'sh800000, 24'sh7fffff, 0, 0, 24'sh1, 24'sh1};
		send_pair(c);
		drain();
	endtask

	task automatic test_random(int count, int span);
		coord_t c[8];
		longint k0, k1;
		for (int i = 0; i < count; i++) begin
			for (int j = 0; j < 8; j++) c[j] = rnd_coord(span);
			case ($urandom_range(0, 3))
				// collinear: q endpoints on the line of p
				0: begin
					k0 = int'($urandom_range(0, 8)) - 2;
					k1 = int'($urandom_range(0, 8)) - 2;
					c[0] = coord_t'(int'($urandom_range(0, 2000)) - 1000);
					c[1] = coord_t'(int'($urandom_range(0, 2000)) - 1000);
					c[2] = c[0] + coord_t'(4 * (int'($urandom_range(0, 400)) - 200));
					c[3] = c[1] + coord_t'(4 * (int'($urandom_range(0, 400)) - 200));
					c[4] = c[0] + coord_t'((c[2] - c[0]) * k0 / 4);
					c[5] = c[1] + coord_t'((c[3] - c[1]) * k0 / 4);
					c[6] = c[0] + coord_t'((c[2] - c[0]) * k1 / 4);
					c[7] = c[1] + coord_t'((c[3] - c[1]) * k1 / 4);
				end
				1: begin
					c[2] = c[0]; // vertical p
				end
				default: ;
			endcase
			send_pair(c);
		end
		drain();
	endtask

	task automatic test_settings;
		write_reg(REG_DET_TOL, 32'd0);
		write_reg(REG_PARAM_TOL, 12'd0);
		test_random(300, 5000);
		write_reg(REG_DET_TOL, 32'hffffffff);
		write_reg(REG_PARAM_TOL, 12'hfff);
		test_random(300, 5000);
		write_reg(REG_DET_TOL, $urandom);
		write_reg(REG_PARAM_TOL, $urandom_range(0, 4095));
		test_random(300, 100000);
	endtask

	task automatic test_no_stall;
		stall_free = 1;
		write_reg(REG_DET_TOL, 32'd1);
		write_reg(REG_PARAM_TOL, 12'd4);
		test_random(300, 5000);
		stall_free = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(400, 5000);
		test_settings();
		test_no_stall();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
